// ===== sv/csim_pkg.sv =====
// ----------------------------------------------------------------------------
// csim_pkg: shared constants and types for the cosine similarity stream
// widths of elements, accumulators, roots and the q1.15 result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csim_pkg;

    localparam int ELEM_BITS     = 16;
    localparam int MAX_LEN       = 65536;
    localparam int OUT_FRAC_BITS = 15;

    localparam int ACC_W  = 48;
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int ROOT_W = ACC_W / 2;
    localparam int CNT_W  = 17;
    localparam int SIM_W  = OUT_FRAC_BITS + 1;
    localparam int DIST_W = OUT_FRAC_BITS + 2;

    localparam int SQ_CNT_W = $clog2(ROOT_W);
    localparam int DV_CNT_W = $clog2(OUT_FRAC_BITS);

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_LEN);
    localparam logic [ACC_W-1:0] SQ_FIRST  = {2'b01, {(ACC_W-2){1'b0}}};
    localparam logic [SIM_W-1:0] ONE_Q     = {1'b1, {OUT_FRAC_BITS{1'b0}}};
    localparam logic [SIM_W-1:0] MAX_POS_Q = {1'b0, {OUT_FRAC_BITS{1'b1}}};

    // running sums and counters handed from the accumulator to the sequencer
    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] norm_a;
        logic [ACC_W-1:0] norm_b;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_acc_out;

endpackage

`default_nettype wire

// ===== sv/csim_acc.sv =====
// ----------------------------------------------------------------------------
// csim_acc: dot product and squared norm accumulators
// one registered product stage, then a 48-bit add per pair
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csim_acc import csim_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_take,
    input  wire logic                        i_clear,
    input  wire logic signed [ELEM_BITS-1:0] i_a,
    input  wire logic signed [ELEM_BITS-1:0] i_b,
    output t_acc_out                         o_acc
);

    logic signed [PROD_W-1:0] r_pab;
    logic signed [PROD_W-1:0] r_paa;
    logic signed [PROD_W-1:0] r_pbb;
    logic                     r_pvld;
    logic [ACC_W-1:0]         r_dot;
    logic [ACC_W-1:0]         r_na;
    logic [ACC_W-1:0]         r_nb;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic                     room;
    logic [ACC_W-1:0]         ext_ab;
    logic [ACC_W-1:0]         ext_aa;
    logic [ACC_W-1:0]         ext_bb;

    assign room   = r_cnt < MAX_CNT;
    assign ext_ab = {{(ACC_W-PROD_W){r_pab[PROD_W-1]}}, r_pab};
    assign ext_aa = {{(ACC_W-PROD_W){r_paa[PROD_W-1]}}, r_paa};
    assign ext_bb = {{(ACC_W-PROD_W){r_pbb[PROD_W-1]}}, r_pbb};

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_take && room) begin
            r_pab <= i_a * i_b;
            r_paa <= i_a * i_a;
            r_pbb <= i_b * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pvld <= 1'b0;
            r_dot  <= '0;
            r_na   <= '0;
            r_nb   <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_pvld <= i_take && room;
            if (i_take && room) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_take && !room) begin
                r_ovf <= 1'b1;
            end
            if (r_pvld) begin
                r_dot <= r_dot + ext_ab;
                r_na  <= r_na + ext_aa;
                r_nb  <= r_nb + ext_bb;
            end
        end
    end

    assign o_acc.dot    = r_dot;
    assign o_acc.norm_a = r_na;
    assign o_acc.norm_b = r_nb;
    assign o_acc.count  = r_cnt;
    assign o_acc.ovf    = r_ovf;

endmodule

`default_nettype wire

// ===== sv/csim_sqrt.sv =====
// ----------------------------------------------------------------------------
// csim_sqrt: iterative floor square root of a 48-bit value
// one result bit per cycle, shared by both norms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csim_sqrt import csim_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ACC_W-1:0]  i_x,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    logic                r_busy;
    logic                r_done;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0]    r_x;
    logic [ACC_W-1:0]    r_res;
    logic [ACC_W-1:0]    r_bit;
    logic [ACC_W-1:0]    trial;
    logic                fits;

    assign trial = r_res + r_bit;
    assign fits  = r_x >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= SQ_FIRST;
        end else if (r_busy) begin
            if (fits) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/csim_div.sv =====
// ----------------------------------------------------------------------------
// csim_div: restoring fractional divider
// magnitude over root product, one quotient bit per cycle, with saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csim_div import csim_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [ACC_W-1:0]         i_mag,
    input  wire logic [ACC_W-1:0]         i_den,
    output logic                          o_done,
    output logic                          o_sat,
    output logic [OUT_FRAC_BITS-1:0]      o_quo
);

    logic                     r_busy;
    logic                     r_done;
    logic [DV_CNT_W-1:0]      r_cnt;
    logic                     r_sat;
    logic [ACC_W-1:0]         r_rem;
    logic [ACC_W-1:0]         r_den;
    logic [OUT_FRAC_BITS-1:0] r_quo;
    logic                     over;
    logic [ACC_W:0]           shifted;
    logic [ACC_W:0]           diff;
    logic                     ge;

    assign over    = i_mag >= i_den;
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !over;
                r_done <= over;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DV_CNT_W'(OUT_FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= over;
            r_rem <= i_mag;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[ACC_W-1:0] : shifted[ACC_W-1:0];
            r_quo <= {r_quo[OUT_FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== sv/cosine_similarity_stream.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_stream: streaming cosine similarity of two vectors
// accumulates dot product and squared norms, then roots, product and divide
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------------
//   in      | into      | i_in_valid / o_in_stall | elem_a, elem_b, last
//   out     | out of    | o_out_valid/ i_out_stall| similarity, distance, flags,
//           |           |                         | pair_count
//
// element pairs go in at one word per cycle while accumulating
// a word with last set holds the input off through the flush state, the root
// launch, two passes of the shared root unit (norm a, then norm b), the
// multiply, the divide launch, the divide and the write-back
// a ratio at or above one, or a zero norm, skips the divide iterations
// reset (i_rst_n low, synchronous) clears the sums, counters and sequencer
// a result waiting on a stalled output holds the sequencer in write-back,
// and the input stays stalled until the output register frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cosine_similarity_stream import csim_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [ELEM_BITS-1:0] i_elem_a,
    input  wire logic signed [ELEM_BITS-1:0] i_elem_b,
    input  wire logic                        i_last,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [SIM_W-1:0]          o_similarity,
    output logic [DIST_W-1:0]                o_distance,
    output logic                             o_zero_norm,
    output logic                             o_too_long,
    output logic [CNT_W-1:0]                 o_pair_count
);

    // sequencer states
    typedef enum logic [8:0] {
        S_ACC   = 9'b000000001,   // taking pairs
        S_FLUSH = 9'b000000010,   // last product lands in the sums
        S_STA   = 9'b000000100,   // launch root of norm a
        S_SQA   = 9'b000001000,   // root of norm a running
        S_SQB   = 9'b000010000,   // root of norm b running
        S_MUL   = 9'b000100000,   // root product and dot magnitude
        S_DSTA  = 9'b001000000,   // launch divide
        S_DIV   = 9'b010000000,   // divide running
        S_OUT   = 9'b100000000    // write result, clear sums
    } t_state;

    t_state               r_state;
    t_state               n_state;
    t_acc_out             acc;
    logic                 take;
    logic                 clear;
    logic                 sq_start;
    logic [ACC_W-1:0]     sq_x;
    logic                 sq_done;
    logic [ROOT_W-1:0]    sq_root;
    logic                 dv_start;
    logic                 dv_done;
    logic                 dv_sat;
    logic [OUT_FRAC_BITS-1:0] dv_quo;
    logic [ROOT_W-1:0]    r_ra;
    logic [ROOT_W-1:0]    r_rb;
    logic [ACC_W-1:0]     r_den;
    logic [ACC_W-1:0]     r_mag;
    logic                 r_neg;
    logic                 r_zero;
    logic                 out_free;
    logic [SIM_W-1:0]     q_full;
    logic [SIM_W-1:0]     sim_val;
    logic [DIST_W-1:0]    dist_val;
    logic                 r_out_valid;
    logic [SIM_W-1:0]     r_sim;
    logic [DIST_W-1:0]    r_dist;
    logic                 r_zero_o;
    logic                 r_long_o;
    logic [CNT_W-1:0]     r_cnt_o;

    assign o_in_stall = (r_state != S_ACC);
    assign take       = i_in_valid && (r_state == S_ACC);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign clear      = (r_state == S_OUT) && out_free;

    csim_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_clear (clear),
        .i_a     (i_elem_a),
        .i_b     (i_elem_b),
        .o_acc   (acc)
    );

    // one root unit serves both norms in turn
    assign sq_x = (r_state == S_SQA) ? acc.norm_b : acc.norm_a;

    csim_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    csim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_mag   (r_mag),
        .i_den   (r_den),
        .o_done  (dv_done),
        .o_sat   (dv_sat),
        .o_quo   (dv_quo)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        sq_start = 1'b0;
        dv_start = 1'b0;
        case (r_state)
            S_ACC: begin
                if (take && i_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_STA;
            end
            S_STA: begin
                sq_start = 1'b1;
                n_state  = S_SQA;
            end
            S_SQA: begin
                if (sq_done) begin
                    sq_start = 1'b1;
                    n_state  = S_SQB;
                end
            end
            S_SQB: begin
                if (sq_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DSTA;
            end
            S_DSTA: begin
                dv_start = 1'b1;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (dv_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // roots, root product and dot magnitude
    always_ff @(posedge i_clk) begin
        if (r_state == S_SQA && sq_done) begin
            r_ra <= sq_root;
        end
        if (r_state == S_SQB && sq_done) begin
            r_rb <= sq_root;
        end
        if (r_state == S_MUL) begin
            r_den  <= r_ra * r_rb;
            r_zero <= (r_ra == '0) || (r_rb == '0);
            r_neg  <= acc.dot[ACC_W-1];
            // the most negative sum negates to itself, which is its magnitude
            r_mag  <= acc.dot[ACC_W-1] ? (~acc.dot + 1'b1) : acc.dot;
        end
    end

    // saturate a ratio at or above one, then apply the sign; a zero norm gives zeros
    always_comb begin
        if (dv_sat) begin
            q_full = r_neg ? ONE_Q : MAX_POS_Q;
        end else begin
            q_full = {1'b0, dv_quo};
        end
        if (r_zero) begin
            sim_val  = '0;
            dist_val = '0;
        end else if (r_neg) begin
            sim_val  = ~q_full + 1'b1;
            dist_val = {1'b0, ONE_Q} + {1'b0, q_full};
        end else begin
            sim_val  = q_full;
            dist_val = {1'b0, ONE_Q} - {1'b0, q_full};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (clear) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_sim    <= sim_val;
            r_dist   <= dist_val;
            r_zero_o <= r_zero;
            r_long_o <= acc.ovf;
            r_cnt_o  <= acc.count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_similarity = r_sim;
    assign o_distance   = r_dist;
    assign o_zero_norm  = r_zero_o;
    assign o_too_long   = r_long_o;
    assign o_pair_count = r_cnt_o;

endmodule

`default_nettype wire

// ===== tb/cosine_similarity_stream_monitor.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_stream_monitor: score predictor and result compare
// watches both channels, predicts each vector's score and checks each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosine_similarity_stream_monitor import csim_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire logic signed [ELEM_BITS-1:0] i_elem_a,
    input  wire logic signed [ELEM_BITS-1:0] i_elem_b,
    input  wire logic                        i_last,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic signed [SIM_W-1:0]     i_similarity,
    input  wire logic [DIST_W-1:0]           i_distance,
    input  wire logic                        i_zero_norm,
    input  wire logic                        i_too_long,
    input  wire logic [CNT_W-1:0]            i_pair_count,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic signed [SIM_W-1:0] sim;
        logic [DIST_W-1:0]       dst;
        logic                    zero;
        logic                    overlong;
        logic [CNT_W-1:0]        count;
    } t_score;

    // running sums of the vector in flight
    logic signed [ACC_W-1:0] dot_sum;
    logic [ACC_W-1:0]        sq_a_sum;
    logic [ACC_W-1:0]        sq_b_sum;
    logic signed [ACC_W-1:0] prod;
    logic [CNT_W-1:0]        pairs;
    logic                    overlong_seen;

    t_score score_q[$];
    t_score want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [ROOT_W-1:0] floor_root(input logic [ACC_W-1:0] x);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] t;
        r = '0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            t = r | (ROOT_W'(1) << i);
            if (ACC_W'(t) * ACC_W'(t) <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic t_score score_of(input logic signed [ACC_W-1:0] dot,
                                        input logic [ACC_W-1:0] na,
                                        input logic [ACC_W-1:0] nb,
                                        input logic ovf,
                                        input logic [CNT_W-1:0] n);
        logic [ROOT_W-1:0] ra;
        logic [ROOT_W-1:0] rb;
        logic [ACC_W-1:0]  den;
        logic [ACC_W-1:0]  mag;
        logic [SIM_W-1:0]  q;
        logic              neg;
        longint unsigned   wide;
        t_score            s;
        ra         = floor_root(na);
        rb         = floor_root(nb);
        s.zero     = (ra == '0) || (rb == '0);
        s.overlong = ovf;
        s.count    = n;
        s.sim      = '0;
        s.dst      = '0;
        if (!s.zero) begin
            den = ra * rb;
            neg = dot[ACC_W-1];
            mag = neg ? -dot : dot;
            // floor roots can push the ratio to one or beyond
            if (mag >= den) begin
                q = neg ? ONE_Q : MAX_POS_Q;
            end else begin
                wide = (64'(mag) << OUT_FRAC_BITS) / 64'(den);
                q    = wide[SIM_W-1:0];
            end
            if (neg) begin
                s.sim = -q;
                s.dst = DIST_W'(ONE_Q) + DIST_W'(q);
            end else begin
                s.sim = q;
                s.dst = DIST_W'(ONE_Q) - DIST_W'(q);
            end
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dot_sum       = '0;
            sq_a_sum      = '0;
            sq_b_sum      = '0;
            pairs         = '0;
            overlong_seen = 1'b0;
            score_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                // pairs past the maximum length are dropped, only flagged
                if (pairs < MAX_CNT) begin
                    prod     = i_elem_a * i_elem_b;
                    dot_sum  = dot_sum + prod;
                    prod     = i_elem_a * i_elem_a;
                    sq_a_sum = sq_a_sum + prod;
                    prod     = i_elem_b * i_elem_b;
                    sq_b_sum = sq_b_sum + prod;
                    pairs    = pairs + 1'b1;
                end else begin
                    overlong_seen = 1'b1;
                end
                if (i_last) begin
                    score_q.push_back(score_of(dot_sum, sq_a_sum, sq_b_sum,
                                               overlong_seen, pairs));
                    dot_sum       = '0;
                    sq_a_sum      = '0;
                    sq_b_sum      = '0;
                    pairs         = '0;
                    overlong_seen = 1'b0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (score_q.size() == 0) begin
                    $error("result word with no vector pending");
                    o_fail_count++;
                end else begin
                    want = score_q.pop_front();
                    if (i_similarity !== want.sim) begin
                        $error("similarity: expected %0d, got %0d", want.sim, i_similarity);
                        o_fail_count++;
                    end
                    if (i_distance !== want.dst) begin
                        $error("distance: expected %0d, got %0d", want.dst, i_distance);
                        o_fail_count++;
                    end
                    if (i_zero_norm !== want.zero) begin
                        $error("zero_norm: expected %0d, got %0d", want.zero, i_zero_norm);
                        o_fail_count++;
                    end
                    if (i_too_long !== want.overlong) begin
                        $error("too_long: expected %0d, got %0d", want.overlong, i_too_long);
                        o_fail_count++;
                    end
                    if (i_pair_count !== want.count) begin
                        $error("pair_count: expected %0d, got %0d", want.count,
                               i_pair_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = score_q.size();
    end

endmodule

// ===== tb/cosine_similarity_stream_tb.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_stream_tb: stimulus and verdict for the similarity stream
// directed extremes, then random vectors under random idling on both
// channels; the monitor predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cosine_similarity_stream_tb;
    import csim_pkg::*;

    // random phase size, the tail of it runs with no idling at all
    localparam int RAND_WORDS   = 1000;
    localparam int QUIET_WORDS  = 150;
    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD    = 800;
    // well over the root, multiply and divide sequence
    localparam int DRAIN_CYCLES = 200;

    typedef enum int {PICK_ANY, PICK_EDGE, PICK_NEAR_ZERO} t_pick;
    typedef enum int {REL_FREE, REL_SAME, REL_NEG, REL_NEAR} t_rel;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [ELEM_BITS-1:0] i_elem_a;
    logic signed [ELEM_BITS-1:0] i_elem_b;
    logic                        i_last;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [SIM_W-1:0]     o_similarity;
    logic [DIST_W-1:0]           o_distance;
    logic                        o_zero_norm;
    logic                        o_too_long;
    logic [CNT_W-1:0]            o_pair_count;

    int fail_count;
    int pending;

    // quiet: no more idling on either side; hold_go: start the long hold-off
    bit quiet   = 1'b0;
    bit hold_go = 1'b0;

    cosine_similarity_stream uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_similarity (o_similarity),
        .o_distance   (o_distance),
        .o_zero_norm  (o_zero_norm),
        .o_too_long   (o_too_long),
        .o_pair_count (o_pair_count)
    );

    cosine_similarity_stream_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_similarity (o_similarity),
        .i_distance   (o_distance),
        .i_zero_norm  (o_zero_norm),
        .i_too_long   (o_too_long),
        .i_pair_count (o_pair_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // element source: any value, the corner values, or a small spread around zero
    function automatic logic signed [ELEM_BITS-1:0] pick_elem(input t_pick style);
        case (style)
            PICK_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return {1'b1, {(ELEM_BITS-1){1'b0}}};
                    1:       return {1'b0, {(ELEM_BITS-1){1'b1}}};
                    2:       return '1;
                    3:       return '0;
                    default: return ELEM_BITS'(1);
                endcase
            end
            PICK_NEAR_ZERO: return ELEM_BITS'($urandom_range(0, 64)) - ELEM_BITS'(32);
            default:        return ELEM_BITS'($urandom);
        endcase
    endfunction

    // offer one word and return at the edge that takes it; outside the quiet
    // tail the sender sometimes drops valid for a burst first
    task automatic put_word(input logic signed [ELEM_BITS-1:0] a,
                            input logic signed [ELEM_BITS-1:0] b,
                            input logic l);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_elem_a   <= a;
        i_elem_b   <= b;
        i_last     <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // receiver: random stall bursts, one long hold-off, then never stalls
    initial begin : rx_side
        int  n;
        bit  v;
        bit  held;
        held = 1'b0;
        i_out_stall <= 1'b0;
        while (!quiet) begin
            if (hold_go && !held) begin
                held = 1'b1;
                repeat (LONG_HOLD) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                n = $urandom_range(1, 17);
                v = ($urandom_range(0, 3) == 0);
                repeat (n) begin
                    @(posedge i_clk);
                    i_out_stall <= v;
                end
            end
        end
        @(posedge i_clk);
        i_out_stall <= 1'b0;
    end

    initial begin : stimulus
        int                          sent;
        int                          len;
        int                          r;
        logic signed [ELEM_BITS-1:0] a;
        logic signed [ELEM_BITS-1:0] b;
        t_rel                        rel;
        t_pick                       style;

        sent = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_elem_a   <= '0;
        i_elem_b   <= '0;
        i_last     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both norms zero, then only one of them
        put_word(16'sd0, 16'sd0, 1'b1);
        put_word(16'sd5, 16'sd0, 1'b1);
        put_word(16'sd0, -16'sd7, 1'b1);
        // single pairs at full scale: ratio at one, both signs
        put_word(16'sd32767, 16'sd32767, 1'b1);
        put_word(-16'sd32768, 16'sd32767, 1'b1);
        put_word(-16'sd32768, -16'sd32768, 1'b1);
        put_word(16'sd32767, -16'sd32768, 1'b1);
        // orthogonal pair of words: similarity exactly zero
        put_word(16'sd1, 16'sd1, 1'b0);
        put_word(16'sd1, -16'sd1, 1'b1);
        // short mixed vector, ratio well inside the range
        put_word(16'sd100, -16'sd200, 1'b0);
        put_word(16'sd300, 16'sd400, 1'b0);
        put_word(-16'sd500, 16'sd123, 1'b1);
        put_word(-16'sd1, 16'sd1, 1'b0);
        put_word(16'sd2, 16'sd3, 1'b1);

        // random vectors, mostly short; the long hold-off lands early on
        hold_go = 1'b1;
        while (sent < RAND_WORDS) begin
            r = $urandom_range(0, 19);
            if (r < 14)
                len = $urandom_range(1, 8);
            else if (r < 19)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 200);
            rel   = t_rel'($urandom_range(0, 3));
            style = t_pick'($urandom_range(0, 2));
            for (int k = 0; k < len; k++) begin
                a = pick_elem(style);
                case (rel)
                    REL_SAME: b = a;
                    REL_NEG:  b = -a;
                    REL_NEAR: b = a + ELEM_BITS'($urandom_range(0, 6)) - ELEM_BITS'(3);
                    default:  b = pick_elem(style);
                endcase
                // an odd stray value keeps the related vectors from being too tidy
                if ($urandom_range(0, 9) == 0)
                    b = pick_elem(PICK_ANY);
                put_word(a, b, k == len - 1);
                sent++;
                if (sent >= RAND_WORDS - QUIET_WORDS)
                    quiet = 1'b1;
            end
        end
        quiet = 1'b1;

        // drop valid, let every pending result drain, then a little more
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("cosine_similarity_stream: match");
        else
            $display("cosine_similarity_stream: mismatch");
        $finish;
    end

    // hard stop far beyond the slowest legitimate run
    initial begin : watchdog
        #2_000_000;
        $display("cosine_similarity_stream: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/csim_pkg.sv
sv/csim_acc.sv
sv/csim_sqrt.sv
sv/csim_div.sv
sv/cosine_similarity_stream.sv
tb/cosine_similarity_stream_monitor.sv
tb/cosine_similarity_stream_tb.sv
